@@ hw/rtl/stq_pkg.sv @@
// ============================================================================
// stq_pkg - shared types and constants of the sorted timeout queue
// request and result payloads, request kinds, sequencer states
// ============================================================================
`default_nettype none

package stq_pkg;

    // request kinds
    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    localparam int          SECS_BITS     = 22;
    localparam logic [31:0] SECONDS_CAP   = 32'd2147483;
    localparam logic [31:0] MS_PER_SECOND = 32'd1000;
    localparam int          KEY_W         = 16;

    typedef struct packed {
        logic [1:0]       kind;
        logic [KEY_W-1:0] timer_key;
        logic [31:0]      deadline;
        logic [31:0]      now;
    } t_in_req;

    typedef struct packed {
        logic               fired;
        logic [KEY_W-1:0]   fired_key;
        logic signed [31:0] wait_ms;
        logic               full_res;
        logic               found;
        logic               last;
    } t_out_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOC_RD,
        S_LOC_CHK,
        S_SH_CHK,
        S_SH_RD,
        S_SH_WR,
        S_INS_CHK,
        S_INS_RD,
        S_INS_CMP,
        S_UP_CHK,
        S_UP_RD,
        S_UP_WR,
        S_TICK_CHK,
        S_TICK_RD,
        S_TICK_CMP,
        S_TICK_EMIT
    } t_state;

    typedef enum logic [1:0] {
        W_HEAD_RD,
        W_CALC,
        W_EMIT,
        W_NONE
    } t_wait_phase;

endpackage

`default_nettype wire

@@ hw/rtl/stq_ram.sv @@
// ============================================================================
// stq_ram - generic single write, single read port ram
// registered read data that holds while no read is issued
// ============================================================================
`default_nettype none

module stq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/sorted_timeout_queue_core.sv @@
// ============================================================================
// sorted_timeout_queue_core - deadline ordered timeout table
// add / cancel / tick requests over a sorted entry ram, one summary per
// request carrying the wait to the earliest deadline in milliseconds
// ============================================================================
//
//  channel   | direction | handshake                | payload
//  ----------+-----------+--------------------------+-------------------------
//  request   | in        | i_req_valid / o_req_stall | i_req (stq_pkg::t_in_req)
//  result    | out       | o_res_valid / i_res_stall | o_res (stq_pkg::t_out_res)
//
//  sequencing: one request at a time; the key search reads and checks each
//  entry, the insert scan checks, reads and compares each entry, every entry
//  moved in a shift is checked, read and written, and the summary reads the
//  head, computes and emits; each popped entry of a tick is checked, read,
//  compared and emitted, and the emit step waits while the output is stalled
//  reset: synchronous active low, empties the table; entry ram is not cleared
//  stalls: a stalled result holds the sequencer in its emit step; the next
//  request is taken while the final summary still waits in the output register
//
`default_nettype none

module sorted_timeout_queue_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int KEY_BITS    = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_req_valid,
    output logic                    o_req_stall,
    input  wire stq_pkg::t_in_req   i_req,
    output logic                    o_res_valid,
    input  wire logic               i_res_stall,
    output stq_pkg::t_out_res       o_res
);

    // stored key width: keys arrive in 16 bits, masked to KEY_BITS when narrower
    localparam int SK = (KEY_BITS < stq_pkg::KEY_W) ? KEY_BITS : stq_pkg::KEY_W;
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int DW = SK + 32;
    localparam int SB = stq_pkg::SECS_BITS;

    // sequencer and working registers
    stq_pkg::t_state      r_state, n_state;
    stq_pkg::t_wait_phase r_wph,   n_wph;
    logic [1:0]    r_kind,  n_kind;
    logic [SK-1:0] r_key,   n_key;
    logic [31:0]   r_dl,    n_dl;
    logic [31:0]   r_now,   n_now;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_i,     n_i;
    logic [CW-1:0] r_j,     n_j;
    logic [CW-1:0] r_pos,   n_pos;
    logic [CW-1:0] r_gap,   n_gap;
    logic          r_found, n_found;
    logic          r_full,  n_full;
    logic          r_empty, n_empty;
    logic [SB-1:0] r_secs,  n_secs;

    // output register
    logic               r_res_valid, n_res_valid;
    stq_pkg::t_out_res  r_res,       n_res;

    // entry ram port signals
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [DW-1:0] w_wr_data;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic [DW-1:0] w_rd_data;
    logic [SK-1:0] w_rd_key;
    logic [31:0]   w_rd_dl;

    // shared deadline compare and subtract
    logic [31:0]   w_cmp_b;
    logic          w_dl_le;
    logic [31:0]   w_diff;
    logic [31:0]   w_ms;

    logic [CW:0]   w_i_inc;
    logic [CW:0]   w_jg;
    logic          w_out_free;
    logic          w_accept;

    stq_ram #(
        .WIDTH (DW),
        .DEPTH (QUEUE_DEPTH)
    ) u_entries (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_rd_key = w_rd_data[DW-1:32];
    assign w_rd_dl  = w_rd_data[31:0];

    // one comparator serves insert scan (against the new deadline), tick pops
    // and the wait computation (against now)
    assign w_cmp_b = (r_state == stq_pkg::S_INS_CMP) ? r_dl : r_now;
    assign w_dl_le = (w_rd_dl <= w_cmp_b);
    assign w_diff  = w_rd_dl - r_now;
    assign w_ms    = 32'(r_secs) * stq_pkg::MS_PER_SECOND;

    assign w_i_inc    = {1'b0, r_i} + (CW+1)'(1);
    assign w_jg       = {1'b0, r_j} + {1'b0, r_gap};
    assign w_out_free = !r_res_valid || !i_res_stall;

    // idle means: main sequencer idle and no summary still being computed
    assign o_req_stall = !((r_state == stq_pkg::S_IDLE) && (r_wph == stq_pkg::W_NONE));
    assign w_accept    = i_req_valid && !o_req_stall;

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stq_pkg::S_IDLE;
            r_wph       <= stq_pkg::W_NONE;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wph       <= n_wph;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_key   <= n_key;
        r_dl    <= n_dl;
        r_now   <= n_now;
        r_i     <= n_i;
        r_j     <= n_j;
        r_pos   <= n_pos;
        r_gap   <= n_gap;
        r_found <= n_found;
        r_full  <= n_full;
        r_empty <= n_empty;
        r_secs  <= n_secs;
        r_res   <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_wph       = r_wph;
        n_kind      = r_kind;
        n_key       = r_key;
        n_dl        = r_dl;
        n_now       = r_now;
        n_count     = r_count;
        n_i         = r_i;
        n_j         = r_j;
        n_pos       = r_pos;
        n_gap       = r_gap;
        n_found     = r_found;
        n_full      = r_full;
        n_empty     = r_empty;
        n_secs      = r_secs;
        n_res       = r_res;
        n_res_valid = r_res_valid;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_j[AW-1:0];
        w_wr_data   = w_rd_data;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_i[AW-1:0];

        // output register drains when taken
        if (r_res_valid && !i_res_stall) begin
            n_res_valid = 1'b0;
        end

        unique case (r_state)
            stq_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_kind  = i_req.kind;
                    n_key   = i_req.timer_key[SK-1:0];
                    n_dl    = i_req.deadline;
                    n_now   = i_req.now;
                    n_found = 1'b0;
                    n_full  = 1'b0;
                    n_i     = '0;
                    if (i_req.kind == stq_pkg::KIND_ADD ||
                        i_req.kind == stq_pkg::KIND_CANCEL) begin
                        if (r_count != '0) begin
                            n_state = stq_pkg::S_LOC_RD;
                        end else if (i_req.kind == stq_pkg::KIND_ADD) begin
                            n_state = stq_pkg::S_INS_CHK;
                        end else begin
                            n_wph = stq_pkg::W_HEAD_RD;
                        end
                    end else if (i_req.kind == stq_pkg::KIND_TICK) begin
                        n_state = stq_pkg::S_TICK_CHK;
                    end else begin
                        // unused kind: summary only
                        n_wph = stq_pkg::W_HEAD_RD;
                    end
                end
            end

            // key search, a read step and a check step per entry
            stq_pkg::S_LOC_RD: begin
                w_rd_en = 1'b1;
                n_state = stq_pkg::S_LOC_CHK;
            end
            stq_pkg::S_LOC_CHK: begin
                if (w_rd_key == r_key) begin
                    n_found = 1'b1;
                    n_j     = r_i;
                    n_gap   = CW'(1);
                    n_state = stq_pkg::S_SH_CHK;
                end else if (w_i_inc < {1'b0, r_count}) begin
                    n_i     = w_i_inc[CW-1:0];
                    n_state = stq_pkg::S_LOC_RD;
                end else if (r_kind == stq_pkg::KIND_ADD) begin
                    n_i = '0;
                    if (r_count == CW'(QUEUE_DEPTH)) begin
                        n_full  = 1'b1;
                        n_state = stq_pkg::S_IDLE;
                        n_wph   = stq_pkg::W_HEAD_RD;
                    end else begin
                        n_state = stq_pkg::S_INS_CHK;
                    end
                end else begin
                    n_state = stq_pkg::S_IDLE;
                    n_wph   = stq_pkg::W_HEAD_RD;
                end
            end

            // close a gap of r_gap entries at r_j by moving the tail down
            stq_pkg::S_SH_CHK: begin
                if (w_jg < {1'b0, r_count}) begin
                    n_state = stq_pkg::S_SH_RD;
                end else begin
                    n_count = r_count - r_gap;
                    n_i     = '0;
                    if (r_kind == stq_pkg::KIND_ADD) begin
                        n_state = stq_pkg::S_INS_CHK;
                    end else begin
                        n_state = stq_pkg::S_IDLE;
                        n_wph   = stq_pkg::W_HEAD_RD;
                    end
                end
            end
            stq_pkg::S_SH_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_jg[AW-1:0];
                n_state   = stq_pkg::S_SH_WR;
            end
            stq_pkg::S_SH_WR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_j[AW-1:0];
                n_j       = r_j + CW'(1);
                n_state   = stq_pkg::S_SH_CHK;
            end

            // insert position: first entry with a later deadline
            stq_pkg::S_INS_CHK: begin
                if (r_i < r_count) begin
                    n_state = stq_pkg::S_INS_RD;
                end else begin
                    n_pos   = r_i;
                    n_j     = r_count;
                    n_state = stq_pkg::S_UP_CHK;
                end
            end
            stq_pkg::S_INS_RD: begin
                w_rd_en = 1'b1;
                n_state = stq_pkg::S_INS_CMP;
            end
            stq_pkg::S_INS_CMP: begin
                if (w_dl_le) begin
                    n_i     = r_i + CW'(1);
                    n_state = stq_pkg::S_INS_CHK;
                end else begin
                    n_pos   = r_i;
                    n_j     = r_count;
                    n_state = stq_pkg::S_UP_CHK;
                end
            end

            // open a slot at r_pos by moving entries up, then write the new one
            stq_pkg::S_UP_CHK: begin
                if (r_j > r_pos) begin
                    n_state = stq_pkg::S_UP_RD;
                end else begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_pos[AW-1:0];
                    w_wr_data = {r_key, r_dl};
                    n_count   = r_count + CW'(1);
                    n_state   = stq_pkg::S_IDLE;
                    n_wph     = stq_pkg::W_HEAD_RD;
                end
            end
            stq_pkg::S_UP_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = AW'(r_j - CW'(1));
                n_state   = stq_pkg::S_UP_WR;
            end
            stq_pkg::S_UP_WR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_j[AW-1:0];
                n_j       = r_j - CW'(1);
                n_state   = stq_pkg::S_UP_CHK;
            end

            // tick: report the due prefix, then drop it in one shift pass
            stq_pkg::S_TICK_CHK: begin
                if (r_i < r_count) begin
                    n_state = stq_pkg::S_TICK_RD;
                end else begin
                    n_j     = '0;
                    n_gap   = r_i;
                    n_state = stq_pkg::S_SH_CHK;
                end
            end
            stq_pkg::S_TICK_RD: begin
                w_rd_en = 1'b1;
                n_state = stq_pkg::S_TICK_CMP;
            end
            stq_pkg::S_TICK_CMP: begin
                if (w_dl_le) begin
                    n_state = stq_pkg::S_TICK_EMIT;
                end else begin
                    n_j     = '0;
                    n_gap   = r_i;
                    n_state = stq_pkg::S_SH_CHK;
                end
            end
            stq_pkg::S_TICK_EMIT: begin
                if (w_out_free) begin
                    n_res_valid            = 1'b1;
                    n_res                  = '0;
                    n_res.fired            = 1'b1;
                    n_res.fired_key[SK-1:0] = w_rd_key;
                    n_i                    = r_i + CW'(1);
                    n_state                = stq_pkg::S_TICK_CHK;
                end
            end

            default: begin
                n_state = stq_pkg::S_IDLE;
            end
        endcase

        // summary: read head, compare and cap, multiply into the output register
        unique case (r_wph)
            stq_pkg::W_HEAD_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = '0;
                n_wph     = stq_pkg::W_CALC;
            end
            stq_pkg::W_CALC: begin
                n_empty = (r_count == '0);
                if (w_dl_le) begin
                    n_secs = '0;
                end else if (w_diff > stq_pkg::SECONDS_CAP) begin
                    n_secs = stq_pkg::SECONDS_CAP[SB-1:0];
                end else begin
                    n_secs = w_diff[SB-1:0];
                end
                n_wph = stq_pkg::W_EMIT;
            end
            stq_pkg::W_EMIT: begin
                if (w_out_free) begin
                    n_res_valid    = 1'b1;
                    n_res          = '0;
                    n_res.wait_ms  = r_empty ? -32'sd1 : signed'(w_ms);
                    n_res.full_res = r_full;
                    n_res.found    = r_found;
                    n_res.last     = 1'b1;
                    n_wph          = stq_pkg::W_NONE;
                end
            end
            stq_pkg::W_NONE: begin
            end
            default: begin
                n_wph = stq_pkg::W_NONE;
            end
        endcase
    end

    // table never holds more than its depth
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    // a dropped add only happens on a full table
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wph == stq_pkg::W_EMIT && r_full) |-> (r_count == CW'(QUEUE_DEPTH)))
        else $error("full reported with free entries");

    // fired results never close a request and carry no add/cancel status
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.fired) |-> (!o_res.last && !o_res.full_res && !o_res.found))
        else $error("fired result with summary fields");

    // a taken request always occupies the sequencer on the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_req_stall)
        else $error("request taken without starting work");

    // summary computation never overlaps the table walk
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wph != stq_pkg::W_NONE) |-> (r_state == stq_pkg::S_IDLE))
        else $error("summary phase while table walk active");

endmodule

`default_nettype wire
